FILE: rtl/dd_odo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_odo_pkg
// Shared widths, codes, command struct and the CORDIC arctangent table for the
// differential drive odometry block.
// ----------------------------------------------------------------------------
package dd_odo_pkg;

  // Parameter defaults and limits
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int MAX_STEPS        = 24;
  localparam int IDX_W            = 5;

  // Datapath widths
  localparam int VEC_W     = 54;  // CORDIC x/y, wide enough for the raw travel difference
  localparam int ANG_W     = 33;  // CORDIC angle accumulator, 32-bit binary angle plus sign
  localparam int MUL_A_W   = 27;
  localparam int MUL_B_W   = 33;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MM_W      = 20;
  localparam int TREAD_W   = 28;
  localparam int BAM_W     = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 28;
  localparam logic [CFG_IDX_W-1:0] REG_MM_PER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TREAD        = 2'd1;
  localparam logic [MM_W-1:0]      MM_RESET         = 20'd57195;
  localparam logic [TREAD_W-1:0]   TREAD_RESET      = 28'd9175040;

  // Item opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_RESET  = 2'd1;
  localparam logic [1:0] OP_ARM    = 2'd2;

  // Inverse CORDIC gain in Q30, and the pre-scaling bound
  localparam logic [31:0] CORDIC_GAIN_INV = 32'h26DD3B6A;
  localparam int          NORM_LIMIT      = 1 << 30;

  // Command word from the sequencer to the CORDIC unit
  typedef struct packed {
    logic             load_vec;
    logic             load_rot;
    logic             norm;
    logic             step;
    logic [IDX_W-1:0] idx;
  } cordic_cmd_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_angle(input logic [IDX_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/dd_odo_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_odo_mul
// Shared unsigned multiplier with a registered product. Used for the wheel
// travel products and for the partial products of the position increments.
// ----------------------------------------------------------------------------
module dd_odo_mul (
  input  logic                             clk_i,
  input  logic [dd_odo_pkg::MUL_A_W-1:0]   a_i,
  input  logic [dd_odo_pkg::MUL_B_W-1:0]   b_i,
  output logic [dd_odo_pkg::MUL_P_W-1:0]   p_o
);

  logic [dd_odo_pkg::MUL_P_W-1:0] p_d;
  logic [dd_odo_pkg::MUL_P_W-1:0] p_q;

  // Form the product
  always_comb begin
    p_d = {{dd_odo_pkg::MUL_B_W{1'b0}}, a_i} * {{dd_odo_pkg::MUL_A_W{1'b0}}, b_i};
  end

  // Hold the product for the next cycle
  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/dd_odo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dd_odo_cordic
// One shared CORDIC stage with x/y/z registers. It pre-scales the vector,
// runs vectoring steps for atan2 and rotation steps for sine and cosine.
// ----------------------------------------------------------------------------
module dd_odo_cordic (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dd_odo_pkg::cordic_cmd_t                 cmd_i,
  input  logic signed [dd_odo_pkg::VEC_W-1:0]     vec_y_i,
  input  logic [dd_odo_pkg::TREAD_W-1:0]          vec_x_i,
  input  logic [dd_odo_pkg::BAM_W-1:0]            bam_i,
  output logic                                    norm_done_o,
  output logic signed [dd_odo_pkg::VEC_W-1:0]     x_o,
  output logic signed [dd_odo_pkg::VEC_W-1:0]     y_o,
  output logic signed [dd_odo_pkg::ANG_W-1:0]     z_o,
  output logic                                    flip_o
);

  localparam int VW = dd_odo_pkg::VEC_W;
  localparam int AW = dd_odo_pkg::ANG_W;

  localparam logic signed [VW-1:0] LIMIT     = VW'(dd_odo_pkg::NORM_LIMIT);
  localparam logic signed [VW-1:0] NEG_LIMIT = -LIMIT;
  localparam logic signed [AW-1:0] QUARTER   = AW'(dd_odo_pkg::NORM_LIMIT);
  localparam logic signed [AW-1:0] NEG_QUART = -QUARTER;
  localparam logic signed [AW-1:0] HALF      = QUARTER <<< 1;
  localparam logic signed [VW-1:0] GAIN_INV  =
    {{(VW-32){1'b0}}, dd_odo_pkg::CORDIC_GAIN_INV};

  logic signed [VW-1:0] x_q, x_d;
  logic signed [VW-1:0] y_q, y_d;
  logic signed [AW-1:0] z_q, z_d;
  logic                 flip_q, flip_d;
  logic                 vec_mode_q, vec_mode_d;

  logic signed [VW-1:0] x_sh4, y_sh4;
  logic signed [VW-1:0] xs, ys;
  logic signed [AW-1:0] angle;
  logic signed [AW-1:0] z_init;
  logic                 dir;
  logic                 wide_now, wide_sh4;

  function automatic logic out_of_range(input logic signed [VW-1:0] v);
    return (v >= LIMIT) || (v <= NEG_LIMIT);
  endfunction

  // Shifted operands and step direction
  always_comb begin
    x_sh4    = x_q >>> 4;
    y_sh4    = y_q >>> 4;
    xs       = x_q >>> cmd_i.idx;
    ys       = y_q >>> cmd_i.idx;
    angle    = {{(AW-32){1'b0}}, dd_odo_pkg::atan_angle(cmd_i.idx)};
    z_init   = {{(AW-32){bam_i[dd_odo_pkg::BAM_W-1]}}, bam_i, {(32-dd_odo_pkg::BAM_W){1'b0}}};
    dir      = vec_mode_q ? ~y_q[VW-1] : z_q[AW-1];
    wide_now = out_of_range(x_q) || out_of_range(y_q);
    wide_sh4 = out_of_range(x_sh4) || out_of_range(y_sh4);
  end

  // Load, pre-scale or advance one step
  always_comb begin
    x_d        = x_q;
    y_d        = y_q;
    z_d        = z_q;
    flip_d     = flip_q;
    vec_mode_d = vec_mode_q;
    if (cmd_i.load_vec) begin
      x_d        = {{(VW-dd_odo_pkg::TREAD_W){1'b0}}, vec_x_i};
      y_d        = vec_y_i;
      z_d        = '0;
      flip_d     = 1'b0;
      vec_mode_d = 1'b1;
    end else if (cmd_i.load_rot) begin
      x_d        = GAIN_INV;
      y_d        = '0;
      vec_mode_d = 1'b0;
      // fold angles beyond a quarter turn by a half turn
      if (z_init > QUARTER) begin
        z_d    = z_init - HALF;
        flip_d = 1'b1;
      end else if (z_init < NEG_QUART) begin
        z_d    = z_init + HALF;
        flip_d = 1'b1;
      end else begin
        z_d    = z_init;
        flip_d = 1'b0;
      end
    end else if (cmd_i.norm) begin
      if (wide_sh4) begin
        x_d = x_sh4;
        y_d = y_sh4;
      end else begin
        x_d = x_q >>> 1;
        y_d = y_q >>> 1;
      end
    end else if (cmd_i.step) begin
      if (dir) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + angle;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - angle;
      end
    end
  end

  // Mode flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_mode_q <= 1'b0;
    end else begin
      vec_mode_q <= vec_mode_d;
    end
  end

  // Vector registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign norm_done_o = ~wide_now;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign z_o         = z_q;
  assign flip_o      = flip_q;

endmodule

FILE: rtl/differential_drive_odometry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning for a two-wheeled robot: travel, heading and X/Y position
// from encoder counts, built around one shared CORDIC stage and multiplier.
// ----------------------------------------------------------------------------
// Each word is handled on its own: a sample word runs two CORDIC passes plus 0 to 9 pre-scale
// shifts between accept and result valid; reset, arm and unused words go straight to output.
// s_axis_tready is high only while the sequencer idles, so a new word is taken only once the
// last result has entered the output register; a stalled result holds the sequencer meanwhile.
// Reset (async, active low) loads the default gains and clears the odometry.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int CORDIC_STEPS = dd_odo_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = dd_odo_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave side
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // left_count, right_count, notify_delta
  input  logic [95:0]                           s_axis_tdata,
  // opcode
  input  logic [1:0]                            s_axis_tuser,
  // master side
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // distance_mm, heading_deg, heading_signed_deg, loc_x_mm, loc_y_mm,
  // distance_reached, zero pad
  output logic [119:0]                          m_axis_tdata,
  // configuration write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [dd_odo_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dd_odo_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int IDX_W     = dd_odo_pkg::IDX_W;
  localparam int VW        = dd_odo_pkg::VEC_W;
  localparam int AW        = dd_odo_pkg::ANG_W;
  localparam int AMW       = dd_odo_pkg::MUL_A_W;
  localparam int BMW       = dd_odo_pkg::MUL_B_W;
  localparam int PMW       = dd_odo_pkg::MUL_P_W;
  localparam int MM_W      = dd_odo_pkg::MM_W;
  localparam int BAM_W     = dd_odo_pkg::BAM_W;
  localparam int NUM_STEPS = (CORDIC_STEPS > dd_odo_pkg::MAX_STEPS) ?
                             dd_odo_pkg::MAX_STEPS : CORDIC_STEPS;
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_STEPS - 1);
  localparam logic [47:0]      FRAC_MASK = 48'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [AW-1:0] ROUND_HALF = AW'(32768);
  localparam logic [8:0]       DEG_FULL  = 9'd360;
  localparam logic [8:0]       DEG_HALF  = 9'd180;
  localparam int               LO_SH_W   = PMW - AMW;  // 33
  localparam int               SUM_W     = 51;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL_L  = 4'd1;
  localparam logic [3:0] ST_MUL_R  = 4'd2;
  localparam logic [3:0] ST_DR     = 4'd3;
  localparam logic [3:0] ST_SUM    = 4'd4;
  localparam logic [3:0] ST_NORM   = 4'd5;
  localparam logic [3:0] ST_VEC    = 4'd6;
  localparam logic [3:0] ST_HEAD   = 4'd7;
  localparam logic [3:0] ST_ROT    = 4'd8;
  localparam logic [3:0] ST_MS_LO  = 4'd9;
  localparam logic [3:0] ST_MS_HI  = 4'd10;
  localparam logic [3:0] ST_MC_LO  = 4'd11;
  localparam logic [3:0] ST_MC_HI  = 4'd12;
  localparam logic [3:0] ST_ACC_Y  = 4'd13;
  localparam logic [3:0] ST_ADD_Y  = 4'd14;
  localparam logic [3:0] ST_OUT    = 4'd15;

  // Control and architectural state
  logic [3:0]            state_q, state_d;
  logic [IDX_W-1:0]      step_q, step_d;
  logic [MM_W-1:0]       mm_q, mm_d;
  logic [dd_odo_pkg::TREAD_W-1:0] tread_q, tread_d;
  logic [31:0]           prev_l_q, prev_l_d;
  logic [31:0]           prev_r_q, prev_r_d;
  logic [47:0]           travel_q, travel_d;
  logic [47:0]           posx_q, posx_d;
  logic [47:0]           posy_q, posy_d;
  logic [47:0]           notify_q, notify_d;
  logic [BAM_W-1:0]      heading_q, heading_d;
  logic                  reached_q, reached_d;
  logic                  out_valid_q, out_valid_d;

  // Working registers
  logic signed [32:0]    dcl_l_q, dcl_l_d;
  logic signed [32:0]    dcl_r_q, dcl_r_d;
  logic signed [VW-1:0]  dl_q, dl_d;
  logic signed [VW-1:0]  dr_q, dr_d;
  logic signed [52:0]    mean_q, mean_d;
  logic [52:0]           mean_mag_q, mean_mag_d;
  logic [LO_SH_W-1:0]    lo_sh_q, lo_sh_d;
  logic [47:0]           r_q, r_d;
  logic [119:0]          out_data_q, out_data_d;

  // Shared units
  dd_odo_pkg::cordic_cmd_t cmd;
  logic                    norm_done;
  logic signed [VW-1:0]    cor_x, cor_y;
  logic signed [AW-1:0]    cor_z;
  logic                    cor_flip;
  logic [AMW-1:0]          mul_a;
  logic [BMW-1:0]          mul_b;
  logic [PMW-1:0]          mul_p;

  // Decoded words and helpers
  logic                    in_acc;
  logic [1:0]              in_op;
  logic signed [31:0]      in_left, in_right, in_notify;
  logic signed [VW-1:0]    vec_y;
  logic signed [VW-1:0]    dsum;
  logic signed [AW-1:0]    z_round;
  logic [BAM_W-1:0]        dh;
  logic [BAM_W-1:0]        rot_bam;
  logic signed [VW-1:0]    y_abs, x_abs;
  logic [BMW-1:0]          sin_mag, cos_mag;
  logic                    neg_x, neg_y;
  logic [SUM_W-1:0]        acc_sum;
  logic [47:0]             nd_ext;
  logic [24:0]             deg_prod;
  logic [8:0]              deg, sdeg;
  logic [31:0]             dist_mm, locx_mm, locy_mm;

  function automatic logic [BMW-1:0] abs33(input logic signed [32:0] v);
    return v[32] ? BMW'(-v) : BMW'(v);
  endfunction

  function automatic logic signed [VW-1:0] signed_prod(input logic [PMW-1:0] p,
                                                      input logic neg);
    logic signed [VW-1:0] m;
    m = p[VW-1:0];
    return neg ? -m : m;
  endfunction

  // truncate a Q-format accumulator toward zero to whole millimetres
  function automatic logic [31:0] trunc_mm(input logic [47:0] acc);
    logic signed [47:0] v;
    v = acc + (acc[47] ? FRAC_MASK : 48'd0);
    return 32'(v >>> FRAC_BITS);
  endfunction

  dd_odo_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .vec_y_i     (vec_y),
    .vec_x_i     (tread_q),
    .bam_i       (rot_bam),
    .norm_done_o (norm_done),
    .x_o         (cor_x),
    .y_o         (cor_y),
    .z_o         (cor_z),
    .flip_o      (cor_flip)
  );

  dd_odo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Unpack words and derive shared operands
  always_comb begin
    in_acc    = s_axis_tvalid & s_axis_tready;
    in_op     = s_axis_tuser;
    in_left   = s_axis_tdata[31:0];
    in_right  = s_axis_tdata[63:32];
    in_notify = s_axis_tdata[95:64];
    vec_y     = dl_q - dr_q;
    dsum      = dl_q + dr_q;
    z_round   = cor_z + ROUND_HALF;
    dh        = z_round[31:16];
    rot_bam   = heading_q + dh;
    y_abs     = cor_y[VW-1] ? -cor_y : cor_y;
    x_abs     = cor_x[VW-1] ? -cor_x : cor_x;
    sin_mag   = y_abs[BMW-1:0];
    cos_mag   = x_abs[BMW-1:0];
    neg_x     = mean_q[52] ^ cor_y[VW-1] ^ cor_flip;
    neg_y     = mean_q[52] ^ cor_x[VW-1] ^ cor_flip;
    acc_sum   = mul_p[SUM_W-1:0] + {{(SUM_W-LO_SH_W){1'b0}}, lo_sh_q};
    nd_ext    = {{16{in_notify[31]}}, in_notify};
    deg_prod  = {9'd0, heading_q} * {16'd0, DEG_FULL};
    deg       = deg_prod[24:16];
    sdeg      = (deg > DEG_HALF) ? (deg - DEG_FULL) : deg;
    dist_mm   = trunc_mm(travel_q);
    locx_mm   = trunc_mm(posx_q);
    locy_mm   = trunc_mm(posy_q);
  end

  // Sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd         = '0;
    cmd.idx     = step_q;
    mul_a       = '0;
    mul_b       = '0;
    mm_d        = mm_q;
    tread_d     = tread_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    travel_d    = travel_q;
    posx_d      = posx_q;
    posy_d      = posy_q;
    notify_d    = notify_q;
    heading_d   = heading_q;
    reached_d   = reached_q;
    dcl_l_d     = dcl_l_q;
    dcl_r_d     = dcl_r_q;
    dl_d        = dl_q;
    dr_d        = dr_q;
    mean_d      = mean_q;
    mean_mag_d  = mean_mag_q;
    lo_sh_d     = lo_sh_q;
    r_d         = r_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;

    // take configuration writes
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        dd_odo_pkg::REG_MM_PER_COUNT: mm_d    = cfg_data_i[MM_W-1:0];
        dd_odo_pkg::REG_TREAD:        tread_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          reached_d = 1'b0;
          state_d   = ST_OUT;
          case (in_op)
            dd_odo_pkg::OP_SAMPLE: begin
              dcl_l_d  = {in_left[31], in_left} - {prev_l_q[31], prev_l_q};
              dcl_r_d  = {in_right[31], in_right} - {prev_r_q[31], prev_r_q};
              prev_l_d = in_left;
              prev_r_d = in_right;
              state_d  = ST_MUL_L;
            end
            dd_odo_pkg::OP_RESET: begin
              travel_d  = '0;
              posx_d    = '0;
              posy_d    = '0;
              heading_d = '0;
              prev_l_d  = in_left;
              prev_r_d  = in_right;
            end
            dd_odo_pkg::OP_ARM: begin
              notify_d = (nd_ext << FRAC_BITS) + travel_q;
            end
            default: ;
          endcase
        end
      end
      // left and right wheel travel through the shared multiplier
      ST_MUL_L: begin
        mul_a   = {{(AMW-MM_W){1'b0}}, mm_q};
        mul_b   = abs33(dcl_l_q);
        state_d = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_a   = {{(AMW-MM_W){1'b0}}, mm_q};
        mul_b   = abs33(dcl_r_q);
        dl_d    = signed_prod(mul_p, dcl_l_q[32]);
        state_d = ST_DR;
      end
      ST_DR: begin
        dr_d    = signed_prod(mul_p, dcl_r_q[32]);
        state_d = ST_SUM;
      end
      // mean travel, load the travel difference for atan2
      ST_SUM: begin
        mean_d       = dsum[VW-1:1];
        cmd.load_vec = 1'b1;
        step_d       = '0;
        state_d      = ST_NORM;
      end
      ST_NORM: begin
        if (norm_done) begin
          state_d = ST_VEC;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      ST_VEC: begin
        cmd.step = 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_HEAD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // advance heading and distance, start sine/cosine of the new heading
      ST_HEAD: begin
        heading_d    = rot_bam;
        travel_d     = travel_q + mean_q[47:0];
        mean_mag_d   = mean_q[52] ? 53'(-mean_q) : 53'(mean_q);
        cmd.load_rot = 1'b1;
        state_d      = ST_ROT;
      end
      ST_ROT: begin
        cmd.step = 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = ST_MS_LO;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // position increments as two partial products each
      ST_MS_LO: begin
        mul_a   = mean_mag_q[AMW-1:0];
        mul_b   = sin_mag;
        state_d = ST_MS_HI;
      end
      ST_MS_HI: begin
        mul_a   = {{(2*AMW-53){1'b0}}, mean_mag_q[52:AMW]};
        mul_b   = sin_mag;
        lo_sh_d = mul_p[PMW-1:AMW];
        state_d = ST_MC_LO;
      end
      ST_MC_LO: begin
        mul_a   = mean_mag_q[AMW-1:0];
        mul_b   = cos_mag;
        r_d     = acc_sum[SUM_W-1:3];
        state_d = ST_MC_HI;
      end
      ST_MC_HI: begin
        mul_a   = {{(2*AMW-53){1'b0}}, mean_mag_q[52:AMW]};
        mul_b   = cos_mag;
        lo_sh_d = mul_p[PMW-1:AMW];
        posx_d  = posx_q + (r_q ^ {48{neg_x}}) + {47'd0, neg_x};
        state_d = ST_ACC_Y;
      end
      ST_ACC_Y: begin
        r_d     = acc_sum[SUM_W-1:3];
        state_d = ST_ADD_Y;
      end
      // Y update and the one-shot distance check
      ST_ADD_Y: begin
        posy_d = posy_q + (r_q ^ {48{neg_y}}) + {47'd0, neg_y};
        if ((notify_q != 48'd0) && ($signed(travel_q) > $signed(notify_q))) begin
          notify_d  = '0;
          reached_d = 1'b1;
        end
        state_d = ST_OUT;
      end
      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {5'd0, reached_q, locy_mm, locx_mm, sdeg, deg, dist_mm};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control, configuration and odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      mm_q        <= dd_odo_pkg::MM_RESET;
      tread_q     <= dd_odo_pkg::TREAD_RESET;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      travel_q    <= '0;
      posx_q      <= '0;
      posy_q      <= '0;
      notify_q    <= '0;
      heading_q   <= '0;
      reached_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      mm_q        <= mm_d;
      tread_q     <= tread_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      travel_q    <= travel_d;
      posx_q      <= posx_d;
      posy_q      <= posy_d;
      notify_q    <= notify_d;
      heading_q   <= heading_d;
      reached_q   <= reached_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    dcl_l_q    <= dcl_l_d;
    dcl_r_q    <= dcl_r_d;
    dl_q       <= dl_d;
    dr_q       <= dr_d;
    mean_q     <= mean_d;
    mean_mag_q <= mean_mag_d;
    lo_sh_q    <= lo_sh_d;
    r_q        <= r_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

endmodule

FILE: bench/differential_drive_odometry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_checker
// Watches the sample, report and gain-write channels of the odometry block.
// Keeps its own dead-reckoning state, works out the report due for every
// accepted word and compares each accepted report field by field.
// ----------------------------------------------------------------------------
module differential_drive_odometry_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  // left_count, right_count, notify_delta
  input  logic [95:0]                       s_tdata_i,
  // opcode
  input  logic [1:0]                        s_tuser_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  // distance_mm, heading_deg, heading_signed_deg, loc_x_mm, loc_y_mm,
  // distance_reached, zero pad
  input  logic [119:0]                      m_tdata_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [dd_odo_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dd_odo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                mismatches_o,
  output int                                pending_o,
  output int                                reports_o,
  output int                                notices_o
);
  import dd_odo_pkg::*;

  localparam int ROT_STEPS = (CORDIC_STEPS_DEF < 24) ? CORDIC_STEPS_DEF : 24;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint UNIT_GAIN_Q30 = 64'sd652032874;

  // atan(2^-i) in 32-bit binary angle units
  localparam longint ATAN_STEP [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic [31:0] distance_mm;
    logic [8:0]  heading_deg;
    logic [8:0]  heading_signed_deg;
    logic [31:0] loc_x_mm;
    logic [31:0] loc_y_mm;
    logic        distance_reached;
  } pose_t;

  // gains and odometry state
  logic [MM_W-1:0]    mm_gain;
  logic [TREAD_W-1:0] tread_gain;
  logic [31:0]        last_left, last_right;
  logic [47:0]        travel_q, pos_x_q, pos_y_q, notify_at;
  logic [BAM_W-1:0]   heading_q;

  pose_t due_reports [$];
  pose_t want, seen;
  int    mismatches, notices, reports;

  // Heading change from the wheel travel difference and the tread
  function automatic logic [15:0] turn_angle(input longint dy, input longint dx);
    longint z, xs, ys;
    z = 0;
    while (dx >= ONE_Q30 || dy >= ONE_Q30 || dy <= -ONE_Q30) begin
      dx = dx >>> 1;
      dy = dy >>> 1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = dx >>> i;
      ys = dy >>> i;
      if (dy >= 0) begin
        dx = dx + ys;
        dy = dy - xs;
        z = z + ATAN_STEP[i];
      end else begin
        dx = dx - ys;
        dy = dy + xs;
        z = z - ATAN_STEP[i];
      end
    end
    z = (z + 32768) >>> 16;
    return z[15:0];
  endfunction

  // Sine and cosine of the heading in Q30, folded into the right half plane
  task automatic unit_vector(input logic [15:0] bam, output longint sn, output longint cs);
    longint z, x, y, xs, ys;
    logic   flip;
    z = longint'($signed({bam, 16'h0000}));
    x = UNIT_GAIN_Q30;
    y = 0;
    flip = 1'b0;
    if (z > ONE_Q30) begin
      z = z - 2 * ONE_Q30;
      flip = 1'b1;
    end else if (z < -ONE_Q30) begin
      z = z + 2 * ONE_Q30;
      flip = 1'b1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_STEP[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // Product scaled down by 2^30, magnitude truncated
  function automatic longint scale_q30(input longint a, input longint s);
    logic [63:0]  ma, ms;
    logic [127:0] p;
    longint       r;
    ma = (a < 0) ? -a : a;
    ms = (s < 0) ? -s : s;
    p = ma * ms;
    r = p[93:30];
    return ((a < 0) != (s < 0)) ? -r : r;
  endfunction

  // Accumulator to whole millimetres, toward zero
  function automatic logic [31:0] whole_mm(input logic [47:0] acc);
    longint v;
    v = longint'($signed(acc));
    if (v < 0) begin
      v = -((-v) >>> FRAC);
    end else begin
      v = v >>> FRAC;
    end
    return v[31:0];
  endfunction

  // Advance the odometry by one word and form the report it is due
  task automatic dead_reckon(input logic [1:0] op, input logic signed [31:0] lc,
                             input logic signed [31:0] rc, input logic signed [31:0] nd,
                             output pose_t rep);
    longint      dl, dr, mean, sn, cs, step, arm_off;
    logic [31:0] deg_prod;
    logic [8:0]  deg;
    rep.distance_reached = 1'b0;
    case (op)
      OP_SAMPLE: begin
        dl = (longint'(lc) - longint'($signed(last_left))) * longint'(mm_gain);
        dr = (longint'(rc) - longint'($signed(last_right))) * longint'(mm_gain);
        mean = (dl + dr) >>> 1;
        last_left = lc;
        last_right = rc;
        travel_q = travel_q + mean[47:0];
        heading_q = heading_q + turn_angle(dl - dr, longint'(tread_gain));
        unit_vector(heading_q, sn, cs);
        step = scale_q30(mean, sn);
        pos_x_q = pos_x_q + step[47:0];
        step = scale_q30(mean, cs);
        pos_y_q = pos_y_q + step[47:0];
        if (notify_at != '0 && $signed(travel_q) > $signed(notify_at)) begin
          notify_at = '0;
          rep.distance_reached = 1'b1;
        end
      end
      OP_RESET: begin
        travel_q = '0;
        pos_x_q = '0;
        pos_y_q = '0;
        heading_q = '0;
        last_left = lc;
        last_right = rc;
      end
      OP_ARM: begin
        arm_off = longint'(nd) <<< FRAC;
        notify_at = travel_q + arm_off[47:0];
      end
      default: ;
    endcase
    deg_prod = {16'h0000, heading_q} * 32'd360;
    deg = deg_prod[24:16];
    rep.distance_mm = whole_mm(travel_q);
    rep.heading_deg = deg;
    rep.heading_signed_deg = (deg > 9'd180) ? deg - 9'd360 : deg;
    rep.loc_x_mm = whole_mm(pos_x_q);
    rep.loc_y_mm = whole_mm(pos_y_q);
  endtask

  task automatic check_field(input string name, input logic signed [63:0] exp_v,
                             input logic signed [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // Track gain writes, retire reports, queue new expectations
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_gain = MM_RESET;
      tread_gain = TREAD_RESET;
      last_left = '0;
      last_right = '0;
      travel_q = '0;
      pos_x_q = '0;
      pos_y_q = '0;
      notify_at = '0;
      heading_q = '0;
      due_reports.delete();
      mismatches = 0;
      notices = 0;
      reports = 0;
      mismatches_o <= 0;
      pending_o <= 0;
      reports_o <= 0;
      notices_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MM_PER_COUNT: mm_gain = cfg_data_i[MM_W-1:0];
          REG_TREAD:        tread_gain = cfg_data_i[TREAD_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.distance_mm = m_tdata_i[31:0];
        seen.heading_deg = m_tdata_i[40:32];
        seen.heading_signed_deg = m_tdata_i[49:41];
        seen.loc_x_mm = m_tdata_i[81:50];
        seen.loc_y_mm = m_tdata_i[113:82];
        seen.distance_reached = m_tdata_i[114];
        reports++;
        if (due_reports.size() == 0) begin
          $error("report word with no expectation pending");
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          if (want.distance_reached) notices++;
          check_field("distance_mm", $signed(want.distance_mm), $signed(seen.distance_mm));
          check_field("heading_deg", want.heading_deg, seen.heading_deg);
          check_field("heading_signed_deg", $signed(want.heading_signed_deg),
                      $signed(seen.heading_signed_deg));
          check_field("loc_x_mm", $signed(want.loc_x_mm), $signed(seen.loc_x_mm));
          check_field("loc_y_mm", $signed(want.loc_y_mm), $signed(seen.loc_y_mm));
          check_field("distance_reached", want.distance_reached, seen.distance_reached);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        dead_reckon(s_tuser_i, s_tdata_i[31:0], s_tdata_i[63:32], s_tdata_i[95:64], want);
        due_reports.push_back(want);
      end
      mismatches_o <= mismatches;
      pending_o <= due_reports.size();
      reports_o <= reports;
      notices_o <= notices;
    end
  end

endmodule

FILE: bench/differential_drive_odometry_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test
// Drives encoder samples, odometry resets and distance arms into the block
// under a series of gain settings, with random gaps on both stream sides.
// A directed opening covers the corner cases; random driving follows.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;
  import dd_odo_pkg::*;

  localparam logic [1:0]           OP_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int PHASE_WORDS    = 85;
  localparam int DRAIN_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [95:0]           s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [119:0]          m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int mismatches, pending, reports, notices;
  logic steady = 1'b0;
  int ready_hold = 0;
  int quiet_cycles = 0;
  int words_sent = 0;
  int samples_sent = 0;
  int settings_used = 1;
  logic signed [31:0] odo_left = '0;
  logic signed [31:0] odo_right = '0;

  differential_drive_odometry dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  differential_drive_odometry_checker odo_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .reports_o    (reports),
    .notices_o    (notices)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none in steady stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the report side at random
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!steady && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 6);
    end
  end

  // Abort when no word moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [31:0] left,
                           input logic [31:0] right, input logic [31:0] delta);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {delta, right, left};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (op == OP_SAMPLE) samples_sent++;
    if (op == OP_SAMPLE || op == OP_RESET) begin
      odo_left = left;
      odo_right = right;
    end
  endtask

  // Drop valid, wait for every report, then let the block go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Load both gains while idle; junk rides in the unused upper bits
  task automatic set_gains(input logic [MM_W-1:0] mm, input logic [TREAD_W-1:0] tread);
    logic [CFG_DATA_W-MM_W-1:0] spare_bits;
    spare_bits = (CFG_DATA_W-MM_W)'($urandom());
    settle();
    cfg_write(REG_MM_PER_COUNT, {spare_bits, mm});
    cfg_write(REG_TREAD, tread);
    cfg_write(REG_SPARE, CFG_DATA_W'($urandom()));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly plausible driving from the last counts, the rest noise
  task automatic random_word();
    int          pick, fwd, skew;
    logic [31:0] l, r, nd;
    pick = $urandom_range(0, 99);
    l = $urandom();
    r = $urandom();
    nd = $urandom();
    if (pick < 70) begin
      fwd = int'($urandom_range(0, 600)) - 150;
      skew = int'($urandom_range(0, 200)) - 100;
      if ($urandom_range(0, 19) == 0) skew = int'($urandom_range(0, 4000)) - 2000;
      send_word(OP_SAMPLE, odo_left + fwd + skew, odo_right + fwd - skew, nd);
    end else if (pick < 80) begin
      if ($urandom_range(0, 7) != 0) nd = int'($urandom_range(0, 700)) - 100;
      send_word(OP_ARM, l, r, nd);
    end else if (pick < 87) begin
      send_word(OP_RESET, l, r, nd);
    end else if (pick < 93) begin
      send_word(OP_SPARE, l, r, nd);
    end else begin
      send_word(OP_SAMPLE, l, r, nd);
    end
  endtask

  task automatic run_phase(input logic [MM_W-1:0] mm, input logic [TREAD_W-1:0] tread,
                           input logic calm);
    set_gains(mm, tread);
    steady <= calm;
    repeat (PHASE_WORDS) random_word();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // standing still, then straight ahead and a gentle turn
    send_word(OP_SAMPLE, 32'd0, 32'd0, 32'd0);
    send_word(OP_SAMPLE, 32'd360, 32'd360, 32'd0);
    send_word(OP_SAMPLE, 32'd540, 32'd720, 32'd0);
    // arm 200 mm ahead and drive past it
    send_word(OP_ARM, 32'd0, 32'd0, 32'd200);
    send_word(OP_SAMPLE, 32'd900, 32'd1080, 32'd0);
    send_word(OP_SAMPLE, 32'd1200, 32'd1380, 32'd0);
    send_word(OP_SAMPLE, 32'd1500, 32'd1680, 32'd0);
    // target already behind: fires on the next sample, even without motion
    send_word(OP_ARM, 32'd0, 32'd0, -32'sd5);
    send_word(OP_SAMPLE, 32'd1500, 32'd1680, 32'd0);
    // reset at the count extremes; arming at zero distance stays disarmed
    send_word(OP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_word(OP_ARM, 32'd0, 32'd0, 32'd0);
    // full-scale count swings in both directions
    send_word(OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
    send_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    // unused opcode with every field at all ones
    send_word(OP_SPARE, '1, '1, '1);
    // notify offset extremes
    send_word(OP_ARM, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h7FFF_FFFF);
    send_word(OP_ARM, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    // reverse travel and spins on the spot
    send_word(OP_RESET, 32'd0, 32'd0, 32'd0);
    send_word(OP_SAMPLE, -32'sd720, -32'sd720, 32'd0);
    send_word(OP_SAMPLE, -32'sd360, -32'sd1440, 32'd0);
    send_word(OP_SAMPLE, 32'd2000, -32'sd3000, 32'd0);
    send_word(OP_SPARE, 32'd0, 32'd0, 32'd0);
    send_word(OP_SAMPLE, -32'sd720, -32'sd720, 32'd0);

    // gain sweeps: defaults, both maxima, zero gain with the narrowest tread,
    // random, sharp turns, zero tread, a typical robot, back to defaults
    run_phase(20'd57195, 28'd9175040, 1'b0);
    run_phase(20'hFFFFF, 28'hFFFFFFF, 1'b1);
    run_phase(20'd0, 28'd1, 1'b0);
    run_phase(MM_W'($urandom_range(1, 20'hFFFFF)), TREAD_W'($urandom_range(1, 28'hFFFFFFF)),
              1'b0);
    run_phase(20'hFFFFF, 28'd1, 1'b1);
    run_phase(20'd1, 28'd0, 1'b0);
    run_phase(MM_W'($urandom_range(1000, 120000)),
              TREAD_W'($urandom_range(3000000, 15000000)), 1'b0);
    run_phase(20'd57195, 28'd9175040, 1'b1);

    settle();
    $display("covered %0d words (%0d encoder samples) under %0d gain settings",
             words_sent, samples_sent, settings_used);
    $display("checked %0d reports, %0d of them distance notifications", reports, notices);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dd_odo_pkg.sv
rtl/dd_odo_mul.sv
rtl/dd_odo_cordic.sv
rtl/differential_drive_odometry.sv
bench/differential_drive_odometry_checker.sv
bench/differential_drive_odometry_test.sv
